// ===== rtl/psev_pkg.sv =====
// Shared types, constants and decode function for the postfix stack evaluator.
`timescale 1ns / 1ps

package psev_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Word widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int OUT_PAD  = 8 - ((VALUE_W + STATUS_W) % 8);
    localparam int OUT_W    = VALUE_W + STATUS_W + OUT_PAD;

    // Divider step count
    localparam int DIV_STEPS = VALUE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // Character classes
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_DIGIT = 3'd1,
        K_ADD   = 3'd2,
        K_SUB   = 3'd3,
        K_MUL   = 3'd4,
        K_DIV   = 3'd5
    } t_kind;

    // Commands from controller to datapath
    typedef struct packed {
        logic    accept;     // latch incoming character
        logic    push;       // push digit of incoming character
        logic    alu_load;   // replace top two with add/sub/mul result
        logic    div_start;  // launch divider on top two
        logic    div_load;   // replace top two with quotient
        logic    err_valid;  // record error if none recorded yet
        t_status err_code;
        logic    finish;     // load output word, clear stack and status
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_kind in_kind;      // class of the character on the input
        t_kind op_kind;      // class of the latched character
        logic  full;
        logic  lt2;
        logic  rhs_zero;
        logic  div_done;
        logic  out_free;
    } t_dp_stat;

    // Classify one character
    function automatic t_kind decode_char(input logic [CHAR_W-1:0] c);
        t_kind k;
        k = K_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            k = K_DIGIT;
        end else if (c == CH_PLUS) begin
            k = K_ADD;
        end else if (c == CH_MINUS) begin
            k = K_SUB;
        end else if (c == CH_STAR) begin
            k = K_MUL;
        end else if (c == CH_SLASH) begin
            k = K_DIV;
        end
        return k;
    endfunction

endpackage

// ===== rtl/psev_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module psev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/psev_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps

module psev_div
    import psev_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [VALUE_W-1:0] i_divisor,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [VALUE_W-1:0]   r_rem;
    logic [VALUE_W-1:0]   r_quo;
    logic [VALUE_W-1:0]   r_den;
    logic                 r_neg;

    logic [VALUE_W:0]     shifted;
    logic [VALUE_W:0]     diff;
    logic [VALUE_W-1:0]   mag_a;
    logic [VALUE_W-1:0]   mag_b;

    // Operand magnitudes
    assign mag_a = i_dividend[VALUE_W-1] ? (VALUE_W'(0) - i_dividend) : i_dividend;
    assign mag_b = i_divisor[VALUE_W-1]  ? (VALUE_W'(0) - i_divisor)  : i_divisor;

    // Trial subtract of one step
    assign shifted = {r_rem, r_quo[VALUE_W-1]};
    assign diff    = shifted - {1'b0, r_den};

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag_a;
            r_den <= mag_b;
            r_neg <= i_dividend[VALUE_W-1] ^ i_divisor[VALUE_W-1];
        end else if (r_busy) begin
            if (!diff[VALUE_W]) begin
                r_rem <= diff[VALUE_W-1:0];
                r_quo <= {r_quo[VALUE_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[VALUE_W-1:0];
                r_quo <= {r_quo[VALUE_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (VALUE_W'(0) - r_quo) : r_quo;

endmodule

// ===== rtl/psev_datapath.sv =====
// Stack datapath: top-of-stack register, stack RAM, ALU, divider, output word register.
`timescale 1ns / 1ps

module psev_datapath
    import psev_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [CHAR_W-1:0] i_char,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [OUT_W-1:0]  o_tdata
);

    logic [CHAR_W-1:0]   r_char;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [VALUE_W-1:0]  r_tos;
    logic [VALUE_W-1:0]  n_tos;
    t_status             r_sticky;
    t_status             n_sticky;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    t_status             r_out_status;

    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    cnt_m2;
    logic                ram_we;
    logic [VALUE_W-1:0]  lhs;
    logic [VALUE_W-1:0]  alu_res;
    logic [VALUE_W-1:0]  product;
    logic [VALUE_W-1:0]  quotient;
    logic                div_done;
    logic [VALUE_W-1:0]  digit_val;
    t_kind               op_kind;

    assign cnt_m1    = r_count - CNT_W'(1);
    assign cnt_m2    = r_count - CNT_W'(2);
    assign ram_we    = i_cmd.push && (r_count != '0);
    assign digit_val = VALUE_W'(i_char - CH_ZERO);
    assign op_kind   = decode_char(r_char);

    // Entries below the top live in RAM; the second entry is always being read
    psev_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_m1[ADDR_W-1:0]),
        .i_wdata (r_tos),
        .i_raddr (cnt_m2[ADDR_W-1:0]),
        .o_rdata (lhs)
    );

    psev_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (lhs),
        .i_divisor  (r_tos),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Add, subtract, multiply on second entry and top
    assign product = lhs * r_tos;
    always_comb begin
        unique case (op_kind)
            K_ADD:   alu_res = lhs + r_tos;
            K_SUB:   alu_res = lhs - r_tos;
            default: alu_res = product;
        endcase
    end

    // Next stack state
    always_comb begin
        n_count  = r_count;
        n_tos    = r_tos;
        n_sticky = r_sticky;
        if (i_cmd.err_valid && (r_sticky == ST_OK)) begin
            n_sticky = i_cmd.err_code;
        end
        priority if (i_cmd.finish) begin
            n_count  = '0;
            n_sticky = ST_OK;
        end else if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
            n_tos   = digit_val;
        end else if (i_cmd.alu_load) begin
            n_count = cnt_m1;
            n_tos   = alu_res;
        end else if (i_cmd.div_load) begin
            n_count = cnt_m1;
            n_tos   = quotient;
        end else begin
            n_count = r_count;
        end
    end

    // Stack control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sticky <= ST_OK;
        end else begin
            r_count  <= n_count;
            r_sticky <= n_sticky;
        end
    end

    // Top of stack and latched character
    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        if (i_cmd.accept) begin
            r_char <= i_char;
        end
    end

    // Output word register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value <= (r_count != '0) ? r_tos : '0;
            if (r_sticky != ST_OK) begin
                r_out_status <= r_sticky;
            end else if (r_count == '0) begin
                r_out_status <= ST_EMPTY;
            end else begin
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {OUT_PAD'(0), r_out_status, r_out_value};

    // Status to controller
    assign o_stat.in_kind  = decode_char(i_char);
    assign o_stat.op_kind  = op_kind;
    assign o_stat.full     = (r_count >= CNT_W'(STACK_DEPTH));
    assign o_stat.lt2      = (r_count < CNT_W'(2));
    assign o_stat.rhs_zero = (r_tos == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_tready;

endmodule

// ===== rtl/psev_ctrl.sv =====
// Controller state machine: sequences push, operator, divide and end-of-expression steps.
`timescale 1ns / 1ps

module psev_ctrl
    import psev_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_tvalid,
    input  logic     i_tlast,
    output logic     o_tready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_last;
    logic   n_last;
    t_state after_op;

    // Where to go once the character is handled
    assign after_op = r_last ? S_FIN : S_IDLE;
    assign o_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '{default: '0, err_code: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (i_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_last       = i_tlast;
                    n_state      = i_tlast ? S_FIN : S_IDLE;
                    unique case (i_stat.in_kind)
                        K_DIGIT: begin
                            if (i_stat.full) begin
                                o_cmd.err_valid = 1'b1;
                                o_cmd.err_code  = ST_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        K_ADD, K_SUB, K_MUL, K_DIV: begin
                            if (i_stat.lt2) begin
                                o_cmd.err_valid = 1'b1;
                                o_cmd.err_code  = ST_UNDERFLOW;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        default: begin
                            o_cmd.accept = 1'b1;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (i_stat.op_kind == K_DIV) begin
                    if (i_stat.rhs_zero) begin
                        o_cmd.err_valid = 1'b1;
                        o_cmd.err_code  = ST_DIVZERO;
                        n_state         = after_op;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.alu_load = 1'b1;
                    n_state        = after_op;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = after_op;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

endmodule

// ===== rtl/postfix_stack_evaluator.sv =====
// A digit, ignored word or underflowing operator is handled in S_IDLE; + - * then pass
// through S_EXEC, / through S_EXEC and S_DIV (32-step divider) unless dividing by zero.
// A last word then goes to S_FIN to load its result; words are taken only in S_IDLE.
// A result waits in an output register; a later last word stalls until it is taken.
// Reset (i_rst_n low at a clock edge) empties the stack, clears status and output valid;
// stack RAM contents are not cleared.
`timescale 1ns / 1ps

module postfix_stack_evaluator
    import psev_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [CHAR_W-1:0] i_s_axis_tdata,   // [7:0] char_code
    input  logic              i_s_axis_tlast,   // end_of_expr
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_W-1:0]  o_m_axis_tdata    // [31:0] value, [34:32] status, zero pad above
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    psev_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .i_tlast  (i_s_axis_tlast),
        .o_tready (o_s_axis_tready),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    psev_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_char   (i_s_axis_tdata),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== verif/tb_postfix_stack_evaluator.sv =====
// Self-checking stream testbench for the postfix stack evaluator.
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator;
    import psev_pkg::*;

    localparam int N_ITEMS      = 1550;
    localparam int IDLE_PCT     = 32;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    // One finished expression: top of stack and status
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_eval_result;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [CHAR_W-1:0] i_s_axis_tdata  = '0;   // [7:0] char_code
    logic              i_s_axis_tlast  = 1'b0; // end_of_expr
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_axis_tdata;         // [31:0] value, [34:32] status, zero pad above

    // Evaluator state kept by the testbench
    logic [VALUE_W-1:0] calc_stack [STACK_DEPTH];
    int                 calc_depth = 0;
    t_status            calc_err   = ST_OK;
    t_eval_result       eval_results_q [$];

    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;
    int mismatches    = 0;
    int items_counted = 0;
    int idle_cycles   = 0;

    postfix_stack_evaluator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit is_active(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
               c == CH_STAR || c == CH_SLASH;
    endfunction

    // Keep only the first fault of an expression
    function automatic void note_fault(input t_status code);
        if (calc_err == ST_OK) begin
            calc_err = code;
        end
    endfunction

    // Signed division truncating toward zero, wrapping on most negative / -1
    function automatic logic [VALUE_W-1:0] quot_trunc(input logic [VALUE_W-1:0] a,
                                                      input logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] ma, mb, q;
        ma = a[VALUE_W-1] ? -a : a;
        mb = b[VALUE_W-1] ? -b : b;
        q  = ma / mb;
        return (a[VALUE_W-1] ^ b[VALUE_W-1]) ? -q : q;
    endfunction

    // Advance the evaluator by one character; return 1 when a result is due
    function automatic bit apply_char(input logic [CHAR_W-1:0] c, input logic last,
                                      output t_eval_result res);
        logic [VALUE_W-1:0] lhs, rhs, acc;
        res = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (calc_depth >= STACK_DEPTH) begin
                note_fault(ST_OVERFLOW);
            end else begin
                calc_stack[calc_depth] = VALUE_W'(c - CH_ZERO);
                calc_depth++;
            end
        end else if (is_active(c)) begin
            if (calc_depth < 2) begin
                note_fault(ST_UNDERFLOW);
            end else begin
                rhs = calc_stack[calc_depth-1];
                lhs = calc_stack[calc_depth-2];
                if (c == CH_SLASH && rhs == '0) begin
                    // leave the stack as it is
                    note_fault(ST_DIVZERO);
                end else begin
                    case (c)
                        CH_PLUS:  acc = lhs + rhs;
                        CH_MINUS: acc = lhs - rhs;
                        CH_STAR:  acc = lhs * rhs;
                        default:  acc = quot_trunc(lhs, rhs);
                    endcase
                    calc_stack[calc_depth-2] = acc;
                    calc_depth--;
                end
            end
        end
        if (!last) begin
            return 1'b0;
        end
        res.value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
        if (calc_err != ST_OK) begin
            res.status = calc_err;
        end else if (calc_depth == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.status = ST_OK;
        end
        calc_depth = 0;
        calc_err   = ST_OK;
        return 1'b1;
    endfunction

    function automatic logic [CHAR_W-1:0] noise_char();
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom_range(0, 255));
        end while (is_active(c));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Send one word, with a random gap ahead of it, and predict its result
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        t_eval_result res;
        if (!tx_calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (o_s_axis_tready !== 1'b1);
        if (apply_char(c, last, res)) begin
            eval_results_q.push_back(res);
        end
        items_counted++;
    endtask

    // Send a run of words, marking the final one last
    task automatic send_chars(input logic [CHAR_W-1:0] chars [$]);
        foreach (chars[i]) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        logic [CHAR_W-1:0] chars [$];
        for (int i = 0; i < s.len(); i++) begin
            chars.push_back(s[i]);
        end
        send_chars(chars);
    endtask

    // Well-formed expression with random digits, operators and sprinkled noise
    task automatic send_postfix(input int max_operands, input int push_pct,
                                input int noise_pct);
        logic [CHAR_W-1:0] chars [$];
        int total, pushed, depth;
        total  = $urandom_range(1, max_operands);
        pushed = 0;
        depth  = 0;
        while (pushed < total || depth > 1) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                chars.push_back(noise_char());
            end
            if (pushed < total && (depth < 2 || $urandom_range(0, 99) < push_pct)) begin
                chars.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
                pushed++;
                depth++;
            end else begin
                chars.push_back(pick_op());
                depth--;
            end
        end
        send_chars(chars);
    endtask

    // Random mix of digits, operators and noise with no structure
    task automatic send_scramble(input int max_len);
        logic [CHAR_W-1:0] chars [$];
        int len, r;
        len = $urandom_range(1, max_len);
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                chars.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
            end else if (r < 75) begin
                chars.push_back(pick_op());
            end else begin
                chars.push_back(noise_char());
            end
        end
        send_chars(chars);
    endtask

    task automatic test_operations();
        send_text("9");
        send_text("73+");
        send_text("37-");
        send_text("98*");
        send_text("92/");
        // negative quotient truncates toward zero
        send_text("07-2/");
    endtask

    task automatic test_error_cases();
        send_text("+");
        send_text("5+");
        send_text("50/");
        // first fault wins, later characters still evaluated
        send_text("+50/");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b0);
        send_text("0");
        send_text(" ");
    endtask

    task automatic test_stack_limits();
        // fill the stack, then push once more as the last word
        send_text("98765432109876543");
    endtask

    task automatic test_wrap_cases();
        logic [CHAR_W-1:0] chars [$];
        // build 2^31 as 8^10 * 2, then divide by -1
        chars.push_back(CHAR_W'(CH_ZERO + 8));
        repeat (9) begin
            chars.push_back(CHAR_W'(CH_ZERO + 8));
            chars.push_back(CH_STAR);
        end
        chars.push_back(CHAR_W'(CH_ZERO + 2));
        chars.push_back(CH_STAR);
        chars.push_back(CH_ZERO);
        chars.push_back(CHAR_W'(CH_ZERO + 1));
        chars.push_back(CH_MINUS);
        chars.push_back(CH_SLASH);
        send_chars(chars);
    endtask

    task automatic test_random_expressions();
        int base, n, r;
        base = items_counted;
        while (items_counted - base < N_ITEMS) begin
            n       = items_counted - base;
            tx_calm = (n > 500 && n < 750);
            rx_calm = tx_calm;
            r       = $urandom_range(0, 99);
            if (r < 70) begin
                send_postfix(($urandom_range(0, 9) == 0) ? STACK_DEPTH : 4, 50, 5);
            end else if (r < 78) begin
                send_postfix(STACK_DEPTH + 2, 90, 0);
            end else if (r < 93) begin
                send_scramble(10);
            end else begin
                send_char(noise_char(), 1'b0);
                send_char(noise_char(), 1'($urandom_range(0, 1)));
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_eval_result want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (eval_results_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with none pending: expected none, got value %0d status %0d",
                         $time, $signed(o_m_axis_tdata[VALUE_W-1:0]),
                         o_m_axis_tdata[VALUE_W +: STATUS_W]);
            end else begin
                want = eval_results_q.pop_front();
                if (o_m_axis_tdata[VALUE_W-1:0] !== want.value) begin
                    mismatches++;
                    $display("%0t: value mismatch: expected %0d, got %0d", $time,
                             $signed(want.value), $signed(o_m_axis_tdata[VALUE_W-1:0]));
                end
                if (o_m_axis_tdata[VALUE_W +: STATUS_W] !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, got %0d", $time,
                             want.status, o_m_axis_tdata[VALUE_W +: STATUS_W]);
                end
            end
        end
        i_m_axis_tready <= rx_calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Abort when neither side moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready === 1'b1) ||
            (o_m_axis_tvalid === 1'b1 && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_operations();
        test_error_cases();
        test_stack_limits();
        test_wrap_cases();
        test_random_expressions();

        // drain the remaining results
        i_s_axis_tvalid <= 1'b0;
        while (eval_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
